// ----- src/sm3_pkg.sv -----
// Shared types and constants for the SM3 hash engine.
`default_nettype none
package sm3_pkg;
  localparam logic [31:0] SM3_TJ_LOW  = 32'h79cc4519;
  localparam logic [31:0] SM3_TJ_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  SM3_PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t SM3_IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } comp_ctl_t;

  function automatic word_t rol32(word_t x, logic [4:0] n);
    rol32 = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic word_t perm0(word_t x);
    perm0 = x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic word_t perm1(word_t x);
    perm1 = x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction
endpackage
`default_nettype wire

// ----- src/sm3_round.sv -----
// Iterative SM3 compression: one round per cycle with rolling message expansion.
`default_nettype none
module sm3_round
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire word_t       blk [16],
  input  wire word_t       cv_in [8],
  output word_t            cv_out [8],
  output comp_ctl_t        ctl
);
  word_t w_r [16];
  word_t w_nxt [16];
  word_t v_r [8];
  word_t v_nxt [8];
  logic [5:0] rnd_r;
  logic busy_r;
  logic done_r;

  word_t a12, s1, s2, fv, gv, t1, t2, konst, wn;
  logic lo;

  always_comb begin
    lo = (rnd_r < 6'd16);
    konst = lo ? SM3_TJ_LOW : SM3_TJ_HIGH;
    a12 = {v_r[0][19:0], v_r[0][31:20]};
    s1 = a12 + v_r[4] + rol32(konst, rnd_r[4:0]);
    s1 = {s1[24:0], s1[31:25]};
    s2 = s1 ^ a12;
    if (lo) begin
      fv = v_r[0] ^ v_r[1] ^ v_r[2];
      gv = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      fv = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gv = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    t1 = fv + v_r[3] + s2 + (w_r[0] ^ w_r[4]);
    t2 = gv + v_r[7] + s1 + w_r[0];
    wn = perm1(w_r[0] ^ w_r[7] ^ {w_r[13][16:0], w_r[13][31:17]})
         ^ {w_r[3][24:0], w_r[3][31:25]} ^ w_r[10];
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
    w_nxt[15] = wn;
    v_nxt[0] = t1;
    v_nxt[1] = v_r[0];
    v_nxt[2] = {v_r[1][22:0], v_r[1][31:23]};
    v_nxt[3] = v_r[2];
    v_nxt[4] = perm0(t2);
    v_nxt[5] = v_r[4];
    v_nxt[6] = {v_r[5][12:0], v_r[5][31:13]};
    v_nxt[7] = v_r[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      w_r <= blk;
      v_r <= cv_in;
    end else if (busy_r) begin
      w_r <= w_nxt;
      v_r <= v_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) cv_out[i] = cv_in[i] ^ v_r[i];
    ctl.start = start;
    ctl.busy  = busy_r;
    ctl.done  = done_r;
  end
endmodule
`default_nettype wire

// ----- src/sm3_hash_engine_unit.sv -----
// Top level of the streaming SM3 hash engine.
// Input: a word that fills a block holds off input through the compression start, 64 rounds and the update.
// A final word is followed by the padding stores, one or two such compressions, then
// eight digest beats, one per cycle while out_ready holds.
// No new word is taken until the single round unit is done with the block (in_ready only in idle).
// Reset: synchronous active-low rst_n loads the initial chaining value, clears length/fill.
`default_nettype none
module sm3_hash_engine_unit
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_msg_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  state_t state_r, state_nxt;
  word_t cv_r [8];
  word_t buf_r [16];
  word_t cv_new [8];
  logic [63:0] len_r;
  logic [3:0]  fill_r;
  logic        pad_r;
  logic        wait_r;
  logic        owe_r;
  logic [2:0]  oidx_r;
  logic        cstart;
  comp_ctl_t   cctl;

  logic        acc;
  logic [2:0]  cnt;
  word_t       padw;
  logic [63:0] len_add;
  logic [63:0] bits;

  sm3_round u_round (
    .clk(clk), .rst_n(rst_n), .start(cstart), .blk(buf_r),
    .cv_in(cv_r), .cv_out(cv_new), .ctl(cctl)
  );

  assign acc = in_valid && in_ready;
  assign cnt = (!in_is_last || in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
  assign len_add = len_r + {61'd0, cnt};
  assign bits = {len_r[60:0], 3'b000};

  always_comb begin
    unique case (cnt)
      3'd1: padw = {in_msg_word[31:24], SM3_PAD_BYTE, 16'd0};
      3'd2: padw = {in_msg_word[31:16], SM3_PAD_BYTE, 8'd0};
      3'd3: padw = {in_msg_word[31:8], SM3_PAD_BYTE};
      default: padw = {SM3_PAD_BYTE, 24'd0};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        if (in_is_last) begin
          state_nxt = (fill_r == 4'd15 || (cnt == 3'd4 && fill_r == 4'd14)) ? ST_COMP
                                                                            : ST_PAD;
        end else if (fill_r == 4'd15) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: if (cctl.done) begin
        if (!pad_r) state_nxt = ST_IDLE;
        else if (wait_r) state_nxt = ST_OUT;
        else state_nxt = ST_PAD;
      end
      ST_PAD: if (!owe_r && (fill_r == 4'd14 || fill_r == 4'd15)) state_nxt = ST_COMP;
      ST_OUT: if (out_ready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    cstart    = (state_r == ST_COMP) && !cctl.busy && !cctl.done;
    out_digest_word = cv_r[oidx_r];
    out_word_index  = oidx_r;
    out_last_word   = (oidx_r == 3'd7);
  end

  // pad_r: final word taken; wait_r: final block loaded; owe_r: pad word due at block start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cv_r    <= SM3_IV;
      len_r   <= '0;
      fill_r  <= '0;
      pad_r   <= 1'b0;
      wait_r  <= 1'b0;
      owe_r   <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (acc) begin
          len_r <= len_add;
          pad_r <= in_is_last;
          wait_r <= 1'b0;
          owe_r <= in_is_last && cnt == 3'd4 && fill_r == 4'd15;
          if (in_is_last && cnt != 3'd4) begin
            buf_r[fill_r] <= padw;
            fill_r <= fill_r + 4'd1;
          end else if (in_is_last && fill_r != 4'd15) begin
            buf_r[fill_r] <= in_msg_word;
            buf_r[fill_r + 4'd1] <= padw;
            fill_r <= fill_r + 4'd2;
          end else begin
            buf_r[fill_r] <= in_msg_word;
            fill_r <= fill_r + 4'd1;
          end
        end
        ST_COMP: if (cctl.done) begin
          cv_r <= cv_new;
          if (wait_r) begin
            oidx_r <= '0;
          end
        end
        ST_PAD: begin
          if (owe_r) begin
            buf_r[0] <= {SM3_PAD_BYTE, 24'd0};
            fill_r <= 4'd1;
            owe_r <= 1'b0;
          end else if (fill_r == 4'd14) begin
            buf_r[14] <= bits[63:32];
            buf_r[15] <= bits[31:0];
            fill_r <= 4'd0;
            wait_r <= 1'b1;
          end else begin
            buf_r[fill_r] <= '0;
            fill_r <= fill_r + 4'd1;
          end
        end
        ST_OUT: if (out_ready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cv_r   <= SM3_IV;
            len_r  <= '0;
            fill_r <= '0;
            pad_r  <= 1'b0;
            wait_r <= 1'b0;
            owe_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cctl.busy |-> !in_ready) else $error("input taken during compression");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cctl.busy) else $error("digest shown during compression");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> in_ready)
    else $error("no return to idle after digest");
`endif
endmodule
`default_nettype wire

// ----- tb/sm3_digest_checker.sv -----
// Checker: predicts SM3 digests from accepted message beats and compares digest beats.
`timescale 1ns / 100ps
module sm3_digest_checker
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_msg_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_is_last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_digest_word,
  input  wire logic [2:0]  out_word_index,
  input  wire logic        out_last_word,
  output int               fail_count,
  output int               pending_words
);
  typedef struct {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        lst;
  } digest_beat_t;

  digest_beat_t digest_q[$];
  logic [31:0] chain[8];
  logic [31:0] blk[16];
  logic [63:0] msg_bytes;
  int          fill;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] p0(logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] p1(logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  task automatic compress();
    logic [31:0] w[68];
    logic [31:0] a, b, c, d, e, f, g, h, k, a12, s1, s2, fv, gv, t1, t2;
    for (int r = 0; r < 16; r++) w[r] = blk[r];
    for (int r = 16; r < 68; r++)
      w[r] = p1(w[r-16] ^ w[r-9] ^ rotl(w[r-3], 15)) ^ rotl(w[r-13], 7) ^ w[r-6];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int r = 0; r < 64; r++) begin
      k = (r < 16) ? SM3_TJ_LOW : SM3_TJ_HIGH;
      a12 = rotl(a, 12);
      s1 = rotl(a12 + e + rotl(k, r), 7);
      s2 = s1 ^ a12;
      if (r < 16) begin
        fv = a ^ b ^ c;
        gv = e ^ f ^ g;
      end else begin
        fv = (a & b) | (a & c) | (b & c);
        gv = (e & f) | (~e & g);
      end
      t1 = fv + d + s2 + (w[r] ^ w[r+4]);
      t2 = gv + h + s1 + w[r];
      d = c; c = rotl(b, 9); b = a; a = t1;
      h = g; g = rotl(f, 19); f = e; e = p0(t2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endtask

  task automatic push_block_word(logic [31:0] w);
    blk[fill] = w;
    fill++;
    if (fill == 16) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic clear_state();
    for (int i = 0; i < 8; i++) chain[i] = SM3_IV[i];
    msg_bytes = '0;
    fill = 0;
  endtask

  task automatic absorb(logic [31:0] word, logic [2:0] cnt, logic lst);
    logic [63:0] bits;
    logic [31:0] pad;
    int n;
    digest_beat_t beat;
    if (!lst) begin
      msg_bytes += 4;
      push_block_word(word);
      return;
    end
    n = (cnt > 4) ? 4 : cnt;
    msg_bytes += n;
    if (n == 4) begin
      push_block_word(word);
      pad = {SM3_PAD_BYTE, 24'h0};
    end else if (n == 0) begin
      pad = {SM3_PAD_BYTE, 24'h0};
    end else begin
      pad = (word & (32'hffffffff << (32 - 8 * n))) | (32'(SM3_PAD_BYTE) << (24 - 8 * n));
    end
    push_block_word(pad);
    if (fill > 14) while (fill != 0) push_block_word('0);
    while (fill < 14) push_block_word('0);
    bits = msg_bytes << 3;
    push_block_word(bits[63:32]);
    push_block_word(bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      beat.dword = chain[i];
      beat.idx = 3'(i);
      beat.lst = (i == 7);
      digest_q = {digest_q, beat};
    end
    clear_state();
  endtask

  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst_n) begin
      clear_state();
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) absorb(in_msg_word, in_byte_count, in_is_last);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest beat %h", out_digest_word);
          fail_count++;
        end else begin
          exp_beat = digest_q.pop_front();
          if (out_digest_word !== exp_beat.dword) begin
            $error("digest_word exp %h got %h", exp_beat.dword, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== exp_beat.idx) begin
            $error("word_index exp %0d got %0d", exp_beat.idx, out_word_index);
            fail_count++;
          end
          if (out_last_word !== exp_beat.lst) begin
            $error("last_word exp %0d got %0d", exp_beat.lst, out_last_word);
            fail_count++;
          end
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

// ----- tb/tb.sv -----
// Testbench top: drives message beats into the SM3 engine and reports the verdict.
`timescale 1ns / 100ps
module tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_msg_word;
  logic [2:0]  in_byte_count;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          pending_words;
  int          burst_left;
  int          stall_mode = 0;

  sm3_hash_engine_unit dut (.*);

  sm3_digest_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall pattern: phases of always-ready, random and heavy stall
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_beat(logic [31:0] w, logic [2:0] cnt, logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      in_msg_word <= $urandom;
      in_byte_count <= 3'($urandom);
      in_is_last <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_msg_word <= w;
    in_byte_count <= cnt;
    in_is_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int nwords, logic [2:0] last_cnt);
    for (int i = 0; i < nwords; i++) send_beat($urandom, 3'($urandom), 1'b0);
    send_beat($urandom, last_cnt, 1'b1);
  endtask

  int sent;
  int n;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_msg_word = '0;
    in_byte_count = '0;
    in_is_last = 1'b0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(32'h61626300, 3'd3, 1'b1);
    send_beat(32'h0, 3'd0, 1'b1);
    send_beat(32'hffffffff, 3'd4, 1'b1);
    send_beat(32'hffffffff, 3'd7, 1'b1);
    send_beat(32'h12345678, 3'd1, 1'b1);
    send_beat(32'hdeadbeef, 3'd2, 1'b1);
    send_message(12, 3'd0);
    send_message(13, 3'd4);
    send_message(13, 3'd3);
    sent = 47;

    while (sent < 410) begin
      case ($urandom_range(0, 3))
        0: n = $urandom_range(12, 17);
        1: n = $urandom_range(28, 33);
        default: n = $urandom_range(0, 20);
      endcase
      send_message(n, 3'($urandom));
      sent += n + 1;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
src/sm3_pkg.sv
src/sm3_round.sv
src/sm3_hash_engine_unit.sv
tb/sm3_digest_checker.sv
tb/tb.sv
